FILE: sv/tcw_pkg.sv
// Shared constants for the text console writer.
// Holds screen geometry, cell layout and character codes; no dependencies.
package tcw_pkg;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int TAB_SPACING    = 8;
  localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;

  localparam int COL_W   = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W   = $clog2(SCREEN_ROWS);
  localparam int ADDR_W  = 11;
  localparam int SWEEP_W = $clog2(CELL_COUNT + 1);
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int CELL_W  = ATTR_W + CHAR_W;
  localparam int KIND_W  = 2;

  localparam logic [CHAR_W-1:0] CH_LINE_FEED = 8'd10;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

endpackage

FILE: sv/text_console_writer.sv
// Text console writer: screen cell store, cursor, scroll/clear/tab sequencer.
// Depends on tcw_pkg and tcw_ram.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | input     | in_valid_i / in_stall_o | kind_i, char_code_i, cell_index_i
//  out     | output    | out_valid_o/out_stall_i | cursor_pos_o, cell_value_o
//  cfg     | input     | cfg_we_i                | cfg_wdata_i (text attribute)
//
// An ordinary character goes through accept, cell write and result; a read goes
// through accept, address, data and result. A tab writes spaces up to the next
// tab stop. Clear walks all 2000 cells, one write per cycle; a scroll copies 1920
// cells through the single RAM read/write port pair (one cell per cycle), then
// blanks the 80 bottom cells. Reset clears the cursor and the attribute (to 7);
// cell contents stay undefined until the first clear. in_stall_o is high while an
// item is in progress; a result held under out_stall_i does not block acceptance.
module text_console_writer
  import tcw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ATTR_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [ADDR_W-1:0] cell_index_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ADDR_W-1:0] cursor_pos_o,
  output logic [CELL_W-1:0] cell_value_o
);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_GLYPH     = 4'd1;
  localparam logic [3:0] ST_NEWLINE   = 4'd2;
  localparam logic [3:0] ST_SCROLL    = 4'd3;
  localparam logic [3:0] ST_BLANK     = 4'd4;
  localparam logic [3:0] ST_CLEAR     = 4'd5;
  localparam logic [3:0] ST_READ      = 4'd6;
  localparam logic [3:0] ST_READ_DATA = 4'd7;
  localparam logic [3:0] ST_DONE      = 4'd8;

  localparam logic [COL_W-1:0]   LAST_COL    = COL_W'(SCREEN_COLUMNS - 1);
  localparam logic [ROW_W-1:0]   LAST_ROW    = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [SWEEP_W-1:0] SWEEP_END   = SWEEP_W'(CELL_COUNT);
  localparam logic [SWEEP_W-1:0] SWEEP_LAST  = SWEEP_W'(CELL_COUNT - 1);
  localparam logic [SWEEP_W-1:0] SWEEP_ROW1  = SWEEP_W'(SCREEN_COLUMNS);
  localparam logic [SWEEP_W-1:0] SWEEP_BOTR  = SWEEP_W'((SCREEN_ROWS - 1) * SCREEN_COLUMNS);
  localparam logic [ADDR_W-1:0]  COLS_ADDR   = ADDR_W'(SCREEN_COLUMNS);
  localparam logic [ADDR_W-1:0]  CELLS_ADDR  = ADDR_W'(CELL_COUNT);

  logic [3:0]         state_q, state_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [ATTR_W-1:0]  attr_q;
  logic [SWEEP_W-1:0] sweep_q, sweep_d;
  logic               copy_vld_q, copy_vld_d;
  logic [ADDR_W-1:0]  copy_dst_q, copy_dst_d;
  logic [CHAR_W-1:0]  glyph_q, glyph_d;
  logic               tab_q, tab_d;
  logic [ADDR_W-1:0]  idx_q, idx_d;
  logic [CELL_W-1:0]  value_q, value_d;
  logic               out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]  out_pos_q, out_pos_d;
  logic [CELL_W-1:0]  out_value_q, out_value_d;

  logic               in_accept;
  logic [ADDR_W-1:0]  cur_addr;
  logic [COL_W-1:0]   col_inc;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [CELL_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [CELL_W-1:0]  ram_rdata;
  logic [CELL_W-1:0]  blank_cell;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cur_addr   = ADDR_W'(row_q) * COLS_ADDR + ADDR_W'(col_q);
  assign col_inc    = col_q + 1'b1;
  assign blank_cell = {attr_q, CH_SPACE};

  // Screen cell store
  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer: one cell write or copy step per cycle
  always_comb begin
    state_d    = state_q;
    col_d      = col_q;
    row_d      = row_q;
    sweep_d    = sweep_q;
    copy_vld_d = 1'b0;
    copy_dst_d = copy_dst_q;
    glyph_d    = glyph_q;
    tab_d      = tab_q;
    idx_d      = idx_q;
    value_d    = value_q;
    ram_we     = 1'b0;
    ram_waddr  = cur_addr;
    ram_wdata  = blank_cell;
    ram_raddr  = '0;
    out_valid_d = out_valid_q && out_stall_i;
    out_pos_d   = out_pos_q;
    out_value_d = out_value_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          idx_d   = cell_index_i;
          value_d = '0;
          tab_d   = (char_code_i == CH_TAB);
          glyph_d = (char_code_i == CH_TAB) ? CH_SPACE : char_code_i;
          case (kind_i)
            KIND_PUT: begin
              state_d = (char_code_i == CH_LINE_FEED) ? ST_NEWLINE : ST_GLYPH;
            end
            KIND_CLEAR: begin
              sweep_d = '0;
              state_d = ST_CLEAR;
            end
            KIND_READ: begin
              state_d = ST_READ;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      // Store one character at the cursor and advance
      ST_GLYPH: begin
        ram_we    = 1'b1;
        ram_waddr = cur_addr;
        ram_wdata = {attr_q, glyph_q};
        if (col_q == LAST_COL) begin
          col_d = '0;
          if (row_q >= LAST_ROW) begin
            row_d   = LAST_ROW;
            sweep_d = SWEEP_ROW1;
            state_d = ST_SCROLL;
          end else begin
            row_d   = row_q + 1'b1;
            state_d = ST_DONE;
          end
        end else begin
          col_d = col_inc;
          if (tab_q && ((col_inc % TAB_SPACING) != 0)) begin
            state_d = ST_GLYPH;
          end else begin
            state_d = ST_DONE;
          end
        end
      end

      // Line feed: column 0, next row or scroll
      ST_NEWLINE: begin
        col_d = '0;
        if (row_q >= LAST_ROW) begin
          row_d   = LAST_ROW;
          sweep_d = SWEEP_ROW1;
          state_d = ST_SCROLL;
        end else begin
          row_d   = row_q + 1'b1;
          state_d = ST_DONE;
        end
      end

      // Copy each cell one row up: read now, write next cycle
      ST_SCROLL: begin
        ram_we    = copy_vld_q;
        ram_waddr = copy_dst_q;
        ram_wdata = ram_rdata;
        if (sweep_q == SWEEP_END) begin
          sweep_d = SWEEP_BOTR;
          state_d = ST_BLANK;
        end else begin
          ram_raddr  = sweep_q[ADDR_W-1:0];
          copy_vld_d = 1'b1;
          copy_dst_d = sweep_q[ADDR_W-1:0] - COLS_ADDR;
          sweep_d    = sweep_q + 1'b1;
        end
      end

      // Blank the bottom row
      ST_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q[ADDR_W-1:0];
        sweep_d   = sweep_q + 1'b1;
        if (sweep_q == SWEEP_LAST) begin
          state_d = ST_DONE;
        end
      end

      // Blank every cell
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q[ADDR_W-1:0];
        sweep_d   = sweep_q + 1'b1;
        if (sweep_q == SWEEP_LAST) begin
          state_d = ST_DONE;
        end
      end

      ST_READ: begin
        ram_raddr = (idx_q < CELLS_ADDR) ? idx_q : '0;
        state_d   = ST_READ_DATA;
      end

      ST_READ_DATA: begin
        value_d = (idx_q < CELLS_ADDR) ? ram_rdata : '0;
        state_d = ST_DONE;
      end

      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_pos_d   = cur_addr;
          out_value_d = value_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      attr_q      <= ATTR_RESET;
      copy_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      copy_vld_q  <= copy_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk_i) begin
    sweep_q     <= sweep_d;
    copy_dst_q  <= copy_dst_d;
    glyph_q     <= glyph_d;
    tab_q       <= tab_d;
    idx_q       <= idx_d;
    value_q     <= value_d;
    out_pos_q   <= out_pos_d;
    out_value_q <= out_value_d;
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_pos_o = out_pos_q;
  assign cell_value_o = out_value_q;

  // Cursor never leaves the screen
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= LAST_COL) && (row_q <= LAST_ROW))
    else $error("cursor out of range");

  // An accepted item always starts a sequence
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q != ST_IDLE))
    else $error("accepted item did not start");

  // Copy writes only happen inside a scroll
  a_copy_scroll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    copy_vld_q |-> (state_q == ST_SCROLL))
    else $error("copy write outside scroll");

  // Cell writes stay inside the store
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_waddr < CELLS_ADDR))
    else $error("cell write out of range");

endmodule

FILE: sv/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the screen cell store.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench for text_console_writer: a shadow screen and cursor predict every result
// while put, clear, read and no-op items run with random idling on both channels.
// Depends on tcw_pkg and the text_console_writer RTL.
module tb_top;
  import tcw_pkg::*;

  // kind code that the block leaves without effect
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
  localparam int RANDOM_ITEMS = 950;
  localparam int PHASES       = 4;
  localparam int MAX_INDEX    = (1 << ADDR_W) - 1;

  typedef struct packed {
    logic [ADDR_W-1:0] cursor_pos;
    logic [CELL_W-1:0] cell_value;
  } console_answer_t;

  // Shadow of the screen and cursor; holds the answers still due from the block.
  class console_scoreboard;
    logic [CELL_W-1:0] screen [CELL_COUNT];
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [ATTR_W-1:0] attr;
    console_answer_t   answers [$];
    int                mismatches;

    function new();
      foreach (screen[i]) screen[i] = '0;
      col        = '0;
      row        = '0;
      attr       = ATTR_RESET;
      mismatches = 0;
    endfunction

    function void set_attr(logic [ATTR_W-1:0] value);
      attr = value;
    endfunction

    function void blank_cells(int first, int count);
      for (int i = 0; i < count && first + i < CELL_COUNT; i++)
        screen[first + i] = {attr, CH_SPACE};
    endfunction

    // Move the cursor to the next row, scrolling on the bottom row.
    function void line_feed();
      col = '0;
      if (row >= SCREEN_ROWS - 1) begin
        row = ROW_W'(SCREEN_ROWS - 1);
        for (int i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLUMNS; i++)
          screen[i] = screen[i + SCREEN_COLUMNS];
        blank_cells((SCREEN_ROWS - 1) * SCREEN_COLUMNS, SCREEN_COLUMNS);
      end else begin
        row = row + 1'b1;
      end
    endfunction

    function void place_glyph(logic [CHAR_W-1:0] ch);
      int addr;
      addr = int'(row) * SCREEN_COLUMNS + int'(col);
      if (addr < CELL_COUNT) screen[addr] = {attr, ch};
      if (col >= SCREEN_COLUMNS - 1) line_feed();
      else col = col + 1'b1;
    endfunction

    // Apply one accepted item and queue the answer it must produce.
    function void note_item(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] ch,
                            logic [ADDR_W-1:0] idx);
      console_answer_t ans;
      ans.cell_value = '0;
      case (kind)
        KIND_PUT: begin
          if (ch == CH_LINE_FEED) begin
            line_feed();
          end else if (ch == CH_TAB) begin
            do place_glyph(CH_SPACE); while ((int'(col) % TAB_SPACING) != 0);
          end else begin
            place_glyph(ch);
          end
        end
        KIND_CLEAR: blank_cells(0, CELL_COUNT);
        KIND_READ: begin
          if (idx < CELL_COUNT) ans.cell_value = screen[idx];
        end
        default: ;
      endcase
      ans.cursor_pos = ADDR_W'(int'(row) * SCREEN_COLUMNS + int'(col));
      answers.push_back(ans);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // Compare one accepted result with the oldest answer due.
    task check_result(logic [ADDR_W-1:0] pos, logic [CELL_W-1:0] value);
      console_answer_t ans;
      if (answers.size() == 0) begin
        report_mismatch($sformatf("result pos %0d value %h with none due", pos, value));
      end else begin
        ans = answers.pop_front();
        if (pos !== ans.cursor_pos)
          report_mismatch($sformatf("cursor_pos %0d, predicted %0d", pos, ans.cursor_pos));
        if (value !== ans.cell_value)
          report_mismatch($sformatf("cell_value %h, predicted %h", value, ans.cell_value));
      end
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [ATTR_W-1:0] cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [KIND_W-1:0] kind_i;
  logic [CHAR_W-1:0] char_code_i;
  logic [ADDR_W-1:0] cell_index_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [ADDR_W-1:0] cursor_pos_o;
  logic [CELL_W-1:0] cell_value_o;

  console_scoreboard sb;
  int                items_sent;

  text_console_writer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cursor_pos_o (cursor_pos_o),
    .cell_value_o (cell_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Idle length: mostly none or short, a few long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Stall the result channel in random stretches, with long open runs now and then.
  initial begin
    int hold;
    int run_len;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      hold = idle_len();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 150)
                                             : $urandom_range(1, 8);
      repeat (run_len) @(negedge clk_i);
    end
  end

  // Check each accepted result.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(cursor_pos_o, cell_value_o);
  end

  // Drive one item after a random gap; return at the falling edge after acceptance.
  task send_item(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] ch, logic [ADDR_W-1:0] idx);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    char_code_i  <= ch;
    cell_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(kind, ch, idx);
    items_sent++;
    @(negedge clk_i);
  endtask

  task put_char(logic [CHAR_W-1:0] ch);
    send_item(KIND_PUT, ch, ADDR_W'($urandom_range(0, MAX_INDEX)));
  endtask

  task read_cell(logic [ADDR_W-1:0] idx);
    send_item(KIND_READ, CHAR_W'($urandom_range(0, 255)), idx);
  endtask

  // Hold off the sender until every answer has come back.
  task drain();
    in_valid_i <= 1'b0;
    while (sb.answers.size() != 0) @(negedge clk_i);
  endtask

  task write_attr(logic [ATTR_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_attr(value);
  endtask

  // One random step: mostly text with line feeds and tabs, some reads and noise.
  task random_step();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      // long line that may wrap past the last column
      n = $urandom_range(70, 90);
      repeat (n) put_char(CHAR_W'($urandom_range(0, 255)));
    end else if (r < 8) begin
      put_char(CH_LINE_FEED);
    end else if (r < 14) begin
      put_char(CH_TAB);
    end else if (r < 22) begin
      if ($urandom_range(0, 9) == 0) read_cell(ADDR_W'($urandom_range(CELL_COUNT, MAX_INDEX)));
      else read_cell(ADDR_W'($urandom_range(0, CELL_COUNT - 1)));
    end else if (r < 23) begin
      send_item(KIND_CLEAR, CHAR_W'($urandom_range(0, 255)),
                ADDR_W'($urandom_range(0, MAX_INDEX)));
    end else if (r < 24) begin
      send_item(KIND_NONE, CHAR_W'($urandom_range(0, 255)),
                ADDR_W'($urandom_range(0, MAX_INDEX)));
    end else begin
      put_char(CHAR_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int stop_at;
    sb           = new();
    items_sent   = 0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    kind_i       = KIND_PUT;
    char_code_i  = '0;
    cell_index_i = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: only written cells are read before the first clear.
    put_char(8'h41);
    read_cell('0);
    send_item(KIND_NONE, 8'hFF, ADDR_W'(MAX_INDEX));
    read_cell(ADDR_W'(MAX_INDEX));
    read_cell(ADDR_W'(CELL_COUNT));
    send_item(KIND_CLEAR, 8'h00, '0);
    read_cell(ADDR_W'(CELL_COUNT - 1));
    read_cell('0);
    put_char(8'hFF);
    put_char(8'h00);
    put_char(CH_TAB);
    put_char(CH_TAB);
    read_cell(ADDR_W'(8));
    put_char(CH_LINE_FEED);
    put_char(CH_TAB);
    read_cell(ADDR_W'(SCREEN_COLUMNS));
    send_item(KIND_CLEAR, 8'hAA, ADDR_W'(MAX_INDEX));
    read_cell(ADDR_W'(2));

    // Random phases, each under its own attribute.
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0:       write_attr(8'h00);
        1:       write_attr(8'hFF);
        default: write_attr(ATTR_W'($urandom_range(1, 254)));
      endcase
      stop_at = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < stop_at) random_step();
    end

    drain();
    repeat (20) @(negedge clk_i);
    if (sb.answers.size() != 0)
      sb.report_mismatch($sformatf("%0d answers never arrived", sb.answers.size()));
    if (sb.mismatches == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

  // Stop a hung run.
  initial begin
    #20_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

FILE: files.f
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/text_console_writer.sv
tb/tb_top.sv
